/* design/delimiter_string_deframer_assert.svh */
// Assertion helpers for the checks in the deframer top-level module.
`ifndef DELIMITER_STRING_DEFRAMER_ASSERT_SVH
`define DELIMITER_STRING_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSD_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define DSD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("deframer check failed");

`endif

/* design/dsd_pkg.sv */
`timescale 1ns / 1ps

package dsd_pkg;

  localparam int MAX_PAYLOAD_DEF   = 64;
  localparam int MAX_DELIMITER_DEF = 4;
  localparam int END_PATTERNS_DEF  = 2;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [2:0] REG_START_PATTERN      = 3'd0;
  localparam logic [2:0] REG_START_LENGTH       = 3'd1;
  localparam logic [2:0] REG_END_PATTERN_FIRST  = 3'd2;
  localparam logic [2:0] REG_END_LENGTH_FIRST   = 3'd3;
  localparam logic [2:0] REG_END_PATTERN_SECOND = 3'd4;
  localparam logic [2:0] REG_END_LENGTH_SECOND  = 3'd5;

  typedef enum logic [1:0] {
    STAT_PAYLOAD  = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_EMPTY,
    RES_TOO_LONG,
    RES_PAYLOAD
  } res_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATUS,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic process;
    logic load_status;
    logic drain;
  } ctrl_cmd_t;

  typedef struct packed {
    res_kind_t kind;
    logic      out_free;
    logic      drain_done;
  } dp_stat_t;

  // True when the newest len bytes of rb equal pat, oldest byte first.
  function automatic logic pattern_hit(input logic [31:0] pat, input logic [2:0] len,
                                       input logic [31:0] rb, input logic [2:0] cnt,
                                       input int limit);
    logic hit;
    hit = 1'b0;
    if (len != 3'd0 && int'(len) <= limit && len <= cnt) begin
      hit = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (i < int'(len)) begin
          if (pat[8*i +: 8] != rb[8*(int'(len) - 1 - i) +: 8]) hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

/* design/dsd_ifs.sv */
`timescale 1ns / 1ps

interface dsd_data_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface dsd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output payload_byte, output status, output last, input ready);
  modport sink   (input valid, input payload_byte, input status, input last, output ready);
endinterface

/* design/dsd_datapath.sv */
`timescale 1ns / 1ps

module dsd_datapath
  import dsd_pkg::*;
#(
  parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF,
  parameter int MAX_DELIMITER = MAX_DELIMITER_DEF,
  parameter int END_PATTERNS  = END_PATTERNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic       command,
  input  logic [7:0] data_byte,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output status_t    out_status,
  output logic       out_last
);

  localparam int STORE_DEPTH = MAX_PAYLOAD + MAX_DELIMITER;
  localparam int PAT_LIMIT   = (MAX_DELIMITER < 4) ? MAX_DELIMITER : 4;
  localparam int USED_ENDS   = (END_PATTERNS < 2) ? END_PATTERNS : 2;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int PW = $clog2(MAX_PAYLOAD + 1);

  logic [31:0] start_pattern, end_pattern_first, end_pattern_second;
  logic [2:0]  start_length, end_length_first, end_length_second;

  logic [7:0]    store [STORE_DEPTH];
  logic [FW-1:0] fill_count, fill_next;
  logic [31:0]   recent_bytes, recent_next;
  logic [2:0]    recent_count, count_next;
  logic          in_frame, frame_next;
  logic          overflowed, ovf_next;

  logic [31:0]   recent_shift;
  logic [2:0]    count_inc;
  logic          hit_first, hit_second, hit_start;
  logic [2:0]    best;
  logic [FW-1:0] frame_len, wr_addr;
  logic          store_we;
  res_kind_t     kind;

  logic [PW-1:0] ptr, drain_len;
  logic          rd_pend, rd_last;
  logic [7:0]    mem_q;
  status_t       pend_status;
  logic          move, issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pattern      <= '0;
      start_length       <= '0;
      end_pattern_first  <= 32'd10;
      end_length_first   <= 3'd1;
      end_pattern_second <= '0;
      end_length_second  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_PATTERN:      start_pattern      <= cfg_data;
        REG_START_LENGTH:       start_length       <= cfg_data[2:0];
        REG_END_PATTERN_FIRST:  end_pattern_first  <= cfg_data;
        REG_END_LENGTH_FIRST:   end_length_first   <= cfg_data[2:0];
        REG_END_PATTERN_SECOND: end_pattern_second <= cfg_data;
        REG_END_LENGTH_SECOND:  end_length_second  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign recent_shift = {recent_bytes[23:0], data_byte};
  assign count_inc    = (recent_count < 3'(PAT_LIMIT)) ? recent_count + 3'd1 : recent_count;

  assign hit_first  = pattern_hit(end_pattern_first, end_length_first,
                                  recent_shift, count_inc, PAT_LIMIT);
  assign hit_second = (USED_ENDS > 1) &&
                      pattern_hit(end_pattern_second, end_length_second,
                                  recent_shift, count_inc, PAT_LIMIT);
  assign hit_start  = pattern_hit(start_pattern, start_length,
                                  recent_shift, count_inc, PAT_LIMIT);

  always_comb begin
    recent_next = recent_bytes;
    count_next  = recent_count;
    frame_next  = in_frame;
    ovf_next    = overflowed;
    fill_next   = fill_count;
    store_we    = 1'b0;
    wr_addr     = fill_count;
    best        = 3'd0;
    frame_len   = '0;
    kind        = RES_NONE;
    if (command == CMD_FLUSH) begin
      frame_next  = 1'b0;
      fill_next   = '0;
      ovf_next    = 1'b0;
      recent_next = '0;
      count_next  = '0;
    end else begin
      recent_next = recent_shift;
      count_next  = count_inc;
      // with no start pattern a frame opens on every data byte outside one
      if (!in_frame && start_length == 3'd0) begin
        frame_next = 1'b1;
        fill_next  = '0;
        ovf_next   = 1'b0;
      end
      if (frame_next) begin
        wr_addr = fill_next;
        if (fill_next < FW'(STORE_DEPTH)) begin
          store_we  = 1'b1;
          fill_next = fill_next + FW'(1);
        end else begin
          ovf_next = 1'b1;
        end
        if (hit_first) best = end_length_first;
        if (hit_second && end_length_second > best) best = end_length_second;
      end
      if (best != 3'd0) begin
        // end reaching back into the start pattern closes silently
        if (fill_next >= FW'(best)) begin
          frame_len = fill_next - FW'(best);
          if (ovf_next || frame_len > FW'(MAX_PAYLOAD)) kind = RES_TOO_LONG;
          else if (frame_len == '0)                    kind = RES_EMPTY;
          else                                         kind = RES_PAYLOAD;
        end
        frame_next = 1'b0;
        fill_next  = '0;
        ovf_next   = 1'b0;
        count_next = '0;
      end else if (start_length != 3'd0 && hit_start) begin
        frame_next = 1'b1;
        fill_next  = '0;
        ovf_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      recent_bytes <= '0;
      recent_count <= '0;
      in_frame     <= 1'b0;
      overflowed   <= 1'b0;
    end else if (cmd.process) begin
      fill_count   <= fill_next;
      recent_bytes <= recent_next;
      recent_count <= count_next;
      in_frame     <= frame_next;
      overflowed   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.process && store_we) store[wr_addr[AW-1:0]] <= data_byte;
    if (issue) mem_q <= store[AW'(ptr)];
  end

  // drain: one read in flight, held in mem_q until the output slot frees
  assign move  = rd_pend && (!out_valid || out_ready);
  assign issue = cmd.drain && (ptr != drain_len) && (!rd_pend || move);

  always_ff @(posedge clk) begin
    if (cmd.process) begin
      ptr         <= '0;
      drain_len   <= PW'(frame_len);
      pend_status <= (kind == RES_TOO_LONG) ? STAT_TOO_LONG : STAT_EMPTY;
    end else if (issue) begin
      ptr     <= ptr + PW'(1);
      rd_last <= (ptr + PW'(1) == drain_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (issue) begin
      rd_pend <= 1'b1;
    end else if (move) begin
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move || cmd.load_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte   <= mem_q;
      out_status <= STAT_PAYLOAD;
      out_last   <= rd_last;
    end else if (cmd.load_status) begin
      out_byte   <= '0;
      out_status <= pend_status;
      out_last   <= 1'b1;
    end
  end

  assign stat.kind       = kind;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.drain_done = (ptr == drain_len) && !rd_pend;

endmodule

/* design/dsd_controller.sv */
`timescale 1ns / 1ps

module dsd_controller
  import dsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output ctrl_cmd_t cmd,
  input  dp_stat_t  stat
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.process     = 1'b0;
    cmd.load_status = 1'b0;
    cmd.drain       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.process = in_valid;
        if (in_valid) begin
          unique case (stat.kind)
            RES_NONE:     state_next = S_IDLE;
            RES_EMPTY:    state_next = S_STATUS;
            RES_TOO_LONG: state_next = S_STATUS;
            RES_PAYLOAD:  state_next = S_DRAIN;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (stat.drain_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/delimiter_string_deframer.sv */
// After the closing beat a status result passes S_STATUS and the output register, payload
// bytes S_DRAIN, the registered frame store read and the output register.
// Throughput: one byte per cycle while no frame closes; a frame of N payload bytes then
// drains at one result per cycle (single read port) while result_ch is ready; input waits.
// Reset: synchronous, active high; config registers take defaults, frame counts and flags
// clear; drain pointer, output data and frame store are not reset and need no clearing pass.
`timescale 1ns / 1ps
`include "delimiter_string_deframer_assert.svh"

module delimiter_string_deframer
  import dsd_pkg::*;
#(
  parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF,
  parameter int MAX_DELIMITER = MAX_DELIMITER_DEF,
  parameter int END_PATTERNS  = END_PATTERNS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dsd_data_if.sink     data_ch,
  dsd_result_if.source result_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_t   out_status;

  dsd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data_ch.valid),
    .in_ready (data_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  dsd_datapath #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .MAX_DELIMITER (MAX_DELIMITER),
    .END_PATTERNS  (END_PATTERNS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (data_ch.command),
    .data_byte  (data_ch.data_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (result_ch.ready),
    .out_valid  (result_ch.valid),
    .out_byte   (result_ch.payload_byte),
    .out_status (out_status),
    .out_last   (result_ch.last)
  );

  assign result_ch.status = out_status;

  `DSD_ASSERT_IMPL(a_status_is_last, clk, rst,
    result_ch.valid && result_ch.status != STAT_PAYLOAD, result_ch.last)
  `DSD_ASSERT_IMPL(a_no_beat_mid_drain, clk, rst,
    cmd.drain && !stat.drain_done, !data_ch.ready)
  `DSD_ASSERT_NEXT(a_payload_drains, clk, rst,
    cmd.process && stat.kind == RES_PAYLOAD, cmd.drain)

endmodule
